// ===== hdl/request_tag_tracker_with_timeout_core_macros.svh =====
// assertion helpers for the request tag tracker, clocked on clk, quiet in rst
`ifndef REQUEST_TAG_TRACKER_WITH_TIMEOUT_CORE_MACROS_SVH
`define REQUEST_TAG_TRACKER_WITH_TIMEOUT_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RTTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RTTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rttc_pkg.sv =====
`default_nettype none

package rttc_pkg;

  // command codes
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // message categories
  localparam logic [3:0] CAT_REQUEST  = 4'd0;
  localparam logic [3:0] CAT_RESPONSE = 4'd1;

  // result kinds
  localparam logic [2:0] KIND_TRACKED     = 3'd0;
  localparam logic [2:0] KIND_UNTRACKED   = 3'd1;
  localparam logic [2:0] KIND_REJECTED    = 3'd2;
  localparam logic [2:0] KIND_MATCHED     = 3'd3;
  localparam logic [2:0] KIND_UNMATCHED   = 3'd4;
  localparam logic [2:0] KIND_UNSUPPORTED = 3'd5;
  localparam logic [2:0] KIND_INVALID     = 3'd6;
  localparam logic [2:0] KIND_TIMED_OUT   = 3'd7;

  // register indexes
  localparam logic REG_DEFAULT_TIMEOUT = 1'b0;
  localparam logic REG_CHECK_INTERVAL  = 1'b1;

  localparam logic [15:0] DEFAULT_TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] CHECK_INTERVAL_RESET  = 16'd1000;

  // timed-out results per sweep
  localparam int MAX_RESULTS = 16;
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  category;
    logic [7:0]  rx_tag;
    logic [15:0] opcode;
    logic [3:0]  link_id;
    logic [15:0] wait_ms;
    logic        send_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_tag;
    logic [15:0] out_opcode;
    logic [3:0]  out_link;
    logic        last;
  } result_t;

  // one table entry as held in the entry store
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] opcode;
    logic [3:0]  link;
    logic [31:0] deadline;
  } entry_t;

  // per-cycle operations requested of the table
  typedef struct packed {
    logic ins;
    logic ord_rd;
    logic ord_wr;
    logic ent_rd;
    logic drop;
    logic set_count;
  } tbl_op_t;

endpackage

`default_nettype wire

// ===== hdl/rttc_table.sv =====
`default_nettype none

module rttc_table #(
  parameter int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  rttc_pkg::tbl_op_t    op,
  input  rttc_pkg::entry_t     ins_data,
  input  wire [IW-1:0]         ord_rd_addr,
  input  wire [IW-1:0]         ord_wr_addr,
  input  wire [IW-1:0]         ord_wr_slot,
  input  wire [IW-1:0]         ent_rd_addr,
  input  wire [IW-1:0]         drop_slot,
  input  wire [CW-1:0]         count_value,
  output logic                 full,
  output logic [CW-1:0]        count,
  output logic [IW-1:0]        ord_rdata,
  output rttc_pkg::entry_t     ent_rdata
);

  // entry store, indexed by slot
  rttc_pkg::entry_t ent_mem [TABLE_DEPTH];
  // order list: slot numbers from oldest to newest
  logic [IW-1:0]    ord_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] lowest_free;
  logic [IW-1:0]          free_slot;

  // isolate lowest free slot, then encode
  assign free_vec    = ~valid;
  assign lowest_free = free_vec & (~free_vec + TABLE_DEPTH'(1));
  assign full        = (count == CW'(TABLE_DEPTH));

  always_comb begin
    free_slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (lowest_free[i]) begin
        free_slot = free_slot | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (op.ins) begin
        valid[free_slot] <= 1'b1;
        count            <= count + CW'(1);
      end
      if (op.drop) begin
        valid[drop_slot] <= 1'b0;
      end
      if (op.set_count) begin
        count <= count_value;
      end
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (op.ins) begin
      ent_mem[free_slot]       <= ins_data;
      ord_mem[count[IW-1:0]]   <= free_slot;
    end else if (op.ord_wr) begin
      ord_mem[ord_wr_addr]     <= ord_wr_slot;
    end
    if (op.ord_rd) begin
      ord_rdata <= ord_mem[ord_rd_addr];
    end
    if (op.ent_rd) begin
      ent_rdata <= ent_mem[ent_rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rttc_ctrl.sv =====
`default_nettype none

module rttc_ctrl #(
  parameter int TABLE_DEPTH = 16,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  rttc_pkg::item_t      item,
  output logic                 result_valid,
  output rttc_pkg::result_t    result,
  input  wire [15:0]           default_timeout,
  input  wire [15:0]           check_interval,
  output rttc_pkg::tbl_op_t    op,
  output rttc_pkg::entry_t     ins_data,
  output logic [IW-1:0]        ord_rd_addr,
  output logic [IW-1:0]        ord_wr_addr,
  output logic [IW-1:0]        ord_wr_slot,
  output logic [IW-1:0]        ent_rd_addr,
  output logic [IW-1:0]        drop_slot,
  output logic [CW-1:0]        count_value,
  input  wire                  full,
  input  wire [CW-1:0]         count,
  input  wire [IW-1:0]         ord_rdata,
  input  rttc_pkg::entry_t     ent_rdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;

  logic [31:0] now_ms;
  logic [15:0] interval_count;
  logic [7:0]  next_tag;

  // scan pointers and pipeline flags
  logic                        sweep;
  logic [CW-1:0]               rd;
  logic [CW-1:0]               wp;
  logic [CW-1:0]               len;
  logic                        s1;
  logic                        s2;
  logic [IW-1:0]               s2_slot;
  logic [rttc_pkg::RES_CW-1:0] removed;
  logic                        hit;
  logic                        pend_valid;
  rttc_pkg::result_t           pend;
  rttc_pkg::item_t             cap;

  logic        accept;
  logic        issue;
  logic        scan_end;
  logic        remove;
  logic        keep;
  logic        expired;
  logic        is_match;
  logic [31:0] age;
  logic [15:0] offset;
  logic [15:0] tick_count;
  logic        sweep_due;

  assign busy   = (state == ST_SCAN);
  assign accept = start && (state == ST_IDLE);

  assign issue    = (state == ST_SCAN) && (rd != len);
  assign scan_end = (state == ST_SCAN) && !issue && !s1 && !s2;

  // deadline not in the future
  assign age     = now_ms - ent_rdata.deadline;
  assign expired = !age[31];

  assign is_match = (ent_rdata.tag == cap.rx_tag) && (ent_rdata.link == cap.link_id) &&
                    (ent_rdata.opcode == cap.opcode);

  assign remove = s2 && (sweep ? (expired && (removed != rttc_pkg::RES_CW'(rttc_pkg::MAX_RESULTS)))
                               : (is_match && !hit));
  assign keep   = s2 && !remove;

  assign offset     = (item.wait_ms != 16'd0) ? item.wait_ms : default_timeout;
  assign tick_count = interval_count + 16'd1;
  assign sweep_due  = (tick_count >= check_interval);

  always_comb begin
    op               = '0;
    op.ins           = accept && (item.command == rttc_pkg::CMD_SEND) &&
                       (item.category == rttc_pkg::CAT_REQUEST) && item.send_ok && !full;
    op.ord_rd        = issue;
    op.ent_rd        = (state == ST_SCAN) && s1;
    op.drop          = remove;
    op.ord_wr        = keep;
    op.set_count     = scan_end;
    ins_data.tag     = next_tag;
    ins_data.opcode  = item.opcode;
    ins_data.link    = item.link_id;
    ins_data.deadline = now_ms + {16'd0, offset};
    ord_rd_addr      = rd[IW-1:0];
    ent_rd_addr      = ord_rdata;
    ord_wr_addr      = wp[IW-1:0];
    ord_wr_slot      = s2_slot;
    drop_slot        = s2_slot;
    count_value      = wp;
  end

  always_ff @(posedge clk) begin
    if (op.ent_rd) begin
      s2_slot <= ord_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_valid   <= 1'b0;
      now_ms         <= '0;
      interval_count <= '0;
      next_tag       <= '0;
      sweep          <= 1'b0;
      rd             <= '0;
      wp             <= '0;
      len            <= '0;
      s1             <= 1'b0;
      s2             <= 1'b0;
      removed        <= '0;
      hit            <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      s1           <= issue;
      s2           <= op.ent_rd;
      case (state)
        ST_IDLE: begin
          if (start) begin
            // scan set-up, used only if a scan starts
            rd         <= '0;
            wp         <= '0;
            len        <= count;
            removed    <= '0;
            hit        <= 1'b0;
            pend_valid <= 1'b0;
            cap        <= item;
            case (item.command)
              rttc_pkg::CMD_SEND: begin
                result_valid      <= 1'b1;
                result.out_opcode <= item.opcode;
                result.out_link   <= item.link_id;
                result.last       <= 1'b1;
                if (item.category == rttc_pkg::CAT_REQUEST) begin
                  next_tag       <= next_tag + 8'd1;
                  result.out_tag <= next_tag;
                  result.kind    <= op.ins ? rttc_pkg::KIND_TRACKED : rttc_pkg::KIND_REJECTED;
                end else begin
                  result.out_tag <= 8'd0;
                  result.kind    <= item.send_ok ? rttc_pkg::KIND_UNTRACKED
                                                 : rttc_pkg::KIND_REJECTED;
                end
              end
              rttc_pkg::CMD_RECV: begin
                if (item.category == rttc_pkg::CAT_RESPONSE) begin
                  state <= ST_SCAN;
                  sweep <= 1'b0;
                end else begin
                  result_valid      <= 1'b1;
                  result.out_tag    <= item.rx_tag;
                  result.out_opcode <= item.opcode;
                  result.out_link   <= item.link_id;
                  result.last       <= 1'b1;
                  result.kind       <= (item.category == rttc_pkg::CAT_REQUEST)
                                       ? rttc_pkg::KIND_UNSUPPORTED : rttc_pkg::KIND_INVALID;
                end
              end
              rttc_pkg::CMD_TICK: begin
                now_ms <= now_ms + 32'd1;
                if (sweep_due) begin
                  interval_count <= '0;
                  state          <= ST_SCAN;
                  sweep          <= 1'b1;
                end else begin
                  interval_count <= tick_count;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd <= rd + CW'(1);
          end
          if (keep) begin
            wp <= wp + CW'(1);
          end
          if (remove) begin
            // hold the new result back until we know whether it is the final one
            removed           <= removed + rttc_pkg::RES_CW'(1);
            hit               <= 1'b1;
            pend_valid        <= 1'b1;
            pend.kind         <= sweep ? rttc_pkg::KIND_TIMED_OUT : rttc_pkg::KIND_MATCHED;
            pend.out_tag      <= ent_rdata.tag;
            pend.out_opcode   <= ent_rdata.opcode;
            pend.out_link     <= ent_rdata.link;
            pend.last         <= 1'b0;
            if (pend_valid) begin
              result_valid <= 1'b1;
              result       <= pend;
            end
          end
          if (scan_end) begin
            state <= ST_IDLE;
            if (pend_valid) begin
              result_valid <= 1'b1;
              result       <= '{kind: pend.kind, out_tag: pend.out_tag,
                                out_opcode: pend.out_opcode, out_link: pend.out_link,
                                last: 1'b1};
            end else if (!sweep) begin
              result_valid      <= 1'b1;
              result.kind       <= rttc_pkg::KIND_UNMATCHED;
              result.out_tag    <= cap.rx_tag;
              result.out_opcode <= cap.opcode;
              result.out_link   <= cap.link_id;
              result.last       <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/request_tag_tracker_with_timeout_core.sv =====
// channel   ports                                    transfer when
// -------   ---------------------------------------  -----------------------------------
// item      start, busy, item                        start high and busy low
// result    result_valid, result                     every cycle result_valid is high
// config    psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite, pready high
//           prdata, pready
//
// a send, a non-response receive, a tick without a sweep or an unused command
// leaves busy low, and the next item may follow at once
// a response or a sweeping tick keeps busy high while the order list is scanned,
// the order list read feeding the entry store read, one entry a cycle
// synchronous reset clears the valid bits and counters and loads the configuration registers with their defaults;
// results cannot be stalled and come from registers

`default_nettype none

`include "request_tag_tracker_with_timeout_core_macros.svh"

module request_tag_tracker_with_timeout_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  rttc_pkg::item_t     item,
  output logic                result_valid,
  output rttc_pkg::result_t   result,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [2:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // configuration registers
  logic [15:0] default_timeout;
  logic [15:0] check_interval;
  logic        cfg_write;

  // control between sequencer and table
  rttc_pkg::tbl_op_t op;
  rttc_pkg::entry_t  ins_data;
  rttc_pkg::entry_t  ent_rdata;
  logic [IW-1:0]     ord_rd_addr;
  logic [IW-1:0]     ord_wr_addr;
  logic [IW-1:0]     ord_wr_slot;
  logic [IW-1:0]     ent_rd_addr;
  logic [IW-1:0]     drop_slot;
  logic [IW-1:0]     ord_rdata;
  logic [CW-1:0]     count_value;
  logic [CW-1:0]     count;
  logic              full;

  // register file: word address in paddr[2], byte lanes ignored
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= rttc_pkg::DEFAULT_TIMEOUT_RESET;
      check_interval  <= rttc_pkg::CHECK_INTERVAL_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        rttc_pkg::REG_DEFAULT_TIMEOUT: default_timeout <= pwdata[15:0];
        rttc_pkg::REG_CHECK_INTERVAL:  check_interval  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rttc_pkg::REG_DEFAULT_TIMEOUT: prdata = {16'd0, default_timeout};
      rttc_pkg::REG_CHECK_INTERVAL:  prdata = {16'd0, check_interval};
      default:                       prdata = '0;
    endcase
  end

  // sequencer: command decode, time keeping, scan of the order list
  rttc_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .result_valid   (result_valid),
    .result         (result),
    .default_timeout(default_timeout),
    .check_interval (check_interval),
    .op             (op),
    .ins_data       (ins_data),
    .ord_rd_addr    (ord_rd_addr),
    .ord_wr_addr    (ord_wr_addr),
    .ord_wr_slot    (ord_wr_slot),
    .ent_rd_addr    (ent_rd_addr),
    .drop_slot      (drop_slot),
    .count_value    (count_value),
    .full           (full),
    .count          (count),
    .ord_rdata      (ord_rdata),
    .ent_rdata      (ent_rdata)
  );

  // table: entry store, order list, valid bits and fill count
  rttc_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .ins_data   (ins_data),
    .ord_rd_addr(ord_rd_addr),
    .ord_wr_addr(ord_wr_addr),
    .ord_wr_slot(ord_wr_slot),
    .ent_rd_addr(ent_rd_addr),
    .drop_slot  (drop_slot),
    .count_value(count_value),
    .full       (full),
    .count      (count),
    .ord_rdata  (ord_rdata),
    .ent_rdata  (ent_rdata)
  );

  // nothing comes out of an idle cycle without a new transfer
  `RTTC_ASSERT_NEXT(a_idle_silent, !busy && !start, !result_valid, "result without a transfer")
  // a send always gives one final result and leaves the block free
  `RTTC_ASSERT_NEXT(a_send_single, start && !busy && item.command == rttc_pkg::CMD_SEND, result_valid && result.last && !busy, "send did not finish in one cycle")
  // a result that is not the final one only comes out during a scan
  `RTTC_ASSERT_NOW(a_more_follows, result_valid && !result.last, busy, "non-final result outside a scan")

endmodule

`default_nettype wire
